// File: src/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and codes for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_CANCEL = 1'b1;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic [2:0] OUT_FILLED    = 3'd0;
    localparam logic [2:0] OUT_RESTED    = 3'd1;
    localparam logic [2:0] OUT_BOOK_FULL = 3'd2;
    localparam logic [2:0] OUT_DUP_ID    = 3'd3;
    localparam logic [2:0] OUT_CANCELLED = 3'd4;
    localparam logic [2:0] OUT_UNKNOWN   = 3'd5;

    localparam int MAX_RESULTS = 64;

    typedef struct packed {
        logic        action;
        logic [31:0] order_id;
        logic        side;
        logic [9:0]  price;
        logic [31:0] quantity;
    } cmd_t;

    typedef struct packed {
        logic        is_trade;
        logic [31:0] taker_id;
        logic [31:0] maker_id;
        logic [9:0]  trade_price;
        logic [31:0] trade_qty;
        logic [2:0]  outcome;
        logic [31:0] rest_qty;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] order_id;
        logic [31:0] quantity;
        logic [9:0]  price;
        logic        side;
    } cell_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_LOAD,
        CELL_SUB,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        cell_t    load;
    } cell_ctrl_t;

    function automatic result_t make_status(input logic [31:0] id, input logic [2:0] outcome,
                                            input logic [31:0] rest);
        result_t r;
        r             = '0;
        r.taker_id    = id;
        r.outcome     = outcome;
        r.rest_qty    = rest;
        r.last        = 1'b1;
        return r;
    endfunction

endpackage

// File: src/lobm_cell.sv
// ----------------------------------------------------------------------------
// lobm_cell
// One resting order of the book; takes the order of its upper neighbor
// during compaction.
// ----------------------------------------------------------------------------
module lobm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lobm_pkg::cell_ctrl_t ctrl,
    input  lobm_pkg::cell_t    upper,
    output lobm_pkg::cell_t    data
);

    logic        valid_reg;
    logic [31:0] id_reg;
    logic [31:0] qty_reg;
    logic [9:0]  price_reg;
    logic        side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            case (ctrl.op)
                lobm_pkg::CELL_SHIFT_IN: valid_reg <= upper.valid;
                lobm_pkg::CELL_LOAD:     valid_reg <= 1'b1;
                lobm_pkg::CELL_CLEAR:    valid_reg <= 1'b0;
                default:                 valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            lobm_pkg::CELL_SHIFT_IN:
            begin
                id_reg    <= upper.order_id;
                qty_reg   <= upper.quantity;
                price_reg <= upper.price;
                side_reg  <= upper.side;
            end
            lobm_pkg::CELL_LOAD:
            begin
                id_reg    <= ctrl.load.order_id;
                qty_reg   <= ctrl.load.quantity;
                price_reg <= ctrl.load.price;
                side_reg  <= ctrl.load.side;
            end
            lobm_pkg::CELL_SUB:
            begin
                qty_reg <= ctrl.load.quantity;
            end
            default:
            begin
            end
        endcase
    end

    assign data = '{valid: valid_reg, order_id: id_reg, quantity: qty_reg,
                    price: price_reg, side: side_reg};

endmodule

// File: src/limit_order_book_matcher_unit.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority order book built as a compacted row of order cells.
// ----------------------------------------------------------------------------
// A cancel, a duplicate or an empty add answers from the lookup state after the transfer.
// An add takes a lookup, then for each fill a scan of every cell plus the fill,
// a closing scan unless the order is used up or the fill limit is reached,
// compaction of the row and a final step.
// A cancel that hits stays busy for compaction after it answers.
// One item at a time; results cannot be stalled. Reset empties the book.
module limit_order_book_matcher_unit #(
    parameter int PRICE_LEVELS = 1024,
    parameter int ORDER_SLOTS  = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lobm_pkg::cmd_t    cmd,
    output logic              result_valid,
    output lobm_pkg::result_t result
);

    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ORDER_SLOTS - 1);
    localparam logic [9:0] PRICE_MAX =
        (PRICE_LEVELS > 1024) ? 10'd1023 : 10'(PRICE_LEVELS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_FILL,
        ST_COMPACT,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    lobm_pkg::cmd_t       cmd_reg;
    logic [31:0]          qty_reg;
    logic [6:0]           fills_reg;
    logic [CW-1:0]        count_reg;
    logic [IW-1:0]        idx_reg;
    logic                 best_found_reg;
    logic [IW-1:0]        best_idx_reg;
    lobm_pkg::cell_t      best_reg;
    lobm_pkg::result_t    pend_reg;
    logic                 pend_valid_reg;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    lobm_pkg::result_t    result_reg;

    lobm_pkg::cell_t      cell_data [ORDER_SLOTS];
    lobm_pkg::cell_t      cell_upper [ORDER_SLOTS];
    lobm_pkg::cell_ctrl_t cell_ctrl [ORDER_SLOTS];

    logic [ORDER_SLOTS-1:0] hit;
    logic [31:0]            hit_qty;
    logic                   hit_any;
    lobm_pkg::cell_t        scan_cell;
    logic                   better;
    logic [31:0]            fill_qty;
    logic [31:0]            maker_left;
    logic [31:0]            qty_left;
    logic [9:0]             price_sat;
    lobm_pkg::cmd_t         cmd_sat;
    lobm_pkg::result_t      fill_result;
    logic [2:0]             final_outcome;
    lobm_pkg::result_t      final_result;

    genvar g;
    generate
        for (g = 0; g < ORDER_SLOTS; g++)
        begin : gen_cell
            if (g == ORDER_SLOTS - 1)
            begin : gen_top
                assign cell_upper[g] = '0;
            end
            else
            begin : gen_mid
                assign cell_upper[g] = cell_data[g+1];
            end
            lobm_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (cell_ctrl[g]),
                .upper (cell_upper[g]),
                .data  (cell_data[g])
            );
        end
    endgenerate

    always_comb
    begin
        hit     = '0;
        hit_qty = '0;
        for (int i = 0; i < ORDER_SLOTS; i++)
        begin
            hit[i] = cell_data[i].valid && (cell_data[i].order_id == cmd_reg.order_id);
            if (hit[i])
            begin
                hit_qty = hit_qty | cell_data[i].quantity;
            end
        end
        hit_any = |hit;
    end

    assign price_sat = ({7'd0, cmd.price} >= 17'(PRICE_LEVELS)) ? PRICE_MAX : cmd.price;

    always_comb
    begin
        cmd_sat       = cmd;
        cmd_sat.price = price_sat;
    end

    always_comb
    begin
        scan_cell = cell_data[idx_reg];
        better    = 1'b0;
        if (scan_cell.valid && (scan_cell.side != cmd_reg.side))
        begin
            if (cmd_reg.side == lobm_pkg::SIDE_BUY)
            begin
                better = (scan_cell.price <= cmd_reg.price) &&
                         (!best_found_reg || (scan_cell.price < best_reg.price));
            end
            else
            begin
                better = (scan_cell.price >= cmd_reg.price) &&
                         (!best_found_reg || (scan_cell.price > best_reg.price));
            end
        end
    end

    assign fill_qty   = (qty_reg < best_reg.quantity) ? qty_reg : best_reg.quantity;
    assign maker_left = best_reg.quantity - fill_qty;
    assign qty_left   = qty_reg - fill_qty;

    always_comb
    begin
        fill_result             = '0;
        fill_result.is_trade    = 1'b1;
        fill_result.taker_id    = cmd_reg.order_id;
        fill_result.maker_id    = best_reg.order_id;
        fill_result.trade_price = best_reg.price;
        fill_result.trade_qty   = fill_qty;
    end

    always_comb
    begin
        if (qty_reg == 32'd0)
        begin
            final_outcome = lobm_pkg::OUT_FILLED;
        end
        else if (count_reg == CW'(ORDER_SLOTS))
        begin
            final_outcome = lobm_pkg::OUT_BOOK_FULL;
        end
        else
        begin
            final_outcome = lobm_pkg::OUT_RESTED;
        end
        if (pend_valid_reg)
        begin
            final_result          = pend_reg;
            final_result.outcome  = final_outcome;
            final_result.rest_qty = qty_reg;
            final_result.last     = 1'b1;
        end
        else
        begin
            final_result = lobm_pkg::make_status(cmd_reg.order_id, final_outcome, qty_reg);
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_LOOKUP:
            begin
                result_valid_next = (cmd_reg.action == lobm_pkg::ACT_CANCEL) || hit_any ||
                                    (qty_reg == 32'd0);
            end
            ST_FILL:
            begin
                result_valid_next = pend_valid_reg;
            end
            ST_FINISH:
            begin
                result_valid_next = 1'b1;
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < ORDER_SLOTS; i++)
        begin
            cell_ctrl[i].op   = lobm_pkg::CELL_HOLD;
            cell_ctrl[i].load = '{valid: 1'b1, order_id: cmd_reg.order_id, quantity: qty_reg,
                                  price: cmd_reg.price, side: cmd_reg.side};
        end
        case (state_reg)
            ST_LOOKUP:
            begin
                if (cmd_reg.action == lobm_pkg::ACT_CANCEL)
                begin
                    for (int i = 0; i < ORDER_SLOTS; i++)
                    begin
                        if (hit[i])
                        begin
                            cell_ctrl[i].op = lobm_pkg::CELL_CLEAR;
                        end
                    end
                end
            end
            ST_FILL:
            begin
                cell_ctrl[best_idx_reg].op =
                    (maker_left == 32'd0) ? lobm_pkg::CELL_CLEAR : lobm_pkg::CELL_SUB;
                cell_ctrl[best_idx_reg].load.quantity = maker_left;
            end
            ST_COMPACT:
            begin
                for (int i = 0; i < ORDER_SLOTS - 1; i++)
                begin
                    if ((idx_reg[0] == 1'(i)) && !cell_data[i].valid && cell_data[i+1].valid)
                    begin
                        cell_ctrl[i].op   = lobm_pkg::CELL_SHIFT_IN;
                        cell_ctrl[i+1].op = lobm_pkg::CELL_CLEAR;
                    end
                end
            end
            ST_FINISH:
            begin
                if (final_outcome == lobm_pkg::OUT_RESTED)
                begin
                    cell_ctrl[count_reg[IW-1:0]].op = lobm_pkg::CELL_LOAD;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
            pend_valid_reg   <= 1'b0;
            best_found_reg   <= 1'b0;
            idx_reg          <= '0;
            fills_reg        <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg        <= cmd_sat;
                        qty_reg        <= cmd.quantity;
                        fills_reg      <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    idx_reg        <= '0;
                    best_found_reg <= 1'b0;
                    if (cmd_reg.action == lobm_pkg::ACT_CANCEL)
                    begin
                        result_reg <= lobm_pkg::make_status(cmd_reg.order_id,
                            hit_any ? lobm_pkg::OUT_CANCELLED : lobm_pkg::OUT_UNKNOWN,
                            hit_any ? hit_qty : 32'd0);
                        if (hit_any)
                        begin
                            count_reg <= count_reg - CW'(1);
                            state_reg <= ST_COMPACT;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (hit_any)
                    begin
                        result_reg <= lobm_pkg::make_status(cmd_reg.order_id,
                                                            lobm_pkg::OUT_DUP_ID, qty_reg);
                        state_reg  <= ST_IDLE;
                    end
                    else if (qty_reg == 32'd0)
                    begin
                        result_reg <= lobm_pkg::make_status(cmd_reg.order_id,
                                                            lobm_pkg::OUT_FILLED, 32'd0);
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (better)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= idx_reg;
                        best_reg       <= scan_cell;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= (best_found_reg || better) ? ST_FILL : ST_COMPACT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                ST_FILL:
                begin
                    if (pend_valid_reg)
                    begin
                        result_reg <= pend_reg;
                    end
                    pend_valid_reg <= 1'b1;
                    pend_reg       <= fill_result;
                    qty_reg        <= qty_left;
                    fills_reg      <= fills_reg + 7'd1;
                    best_found_reg <= 1'b0;
                    idx_reg        <= '0;
                    if (maker_left == 32'd0)
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                    if ((qty_left == 32'd0) ||
                        (fills_reg + 7'd1 == 7'(lobm_pkg::MAX_RESULTS)))
                    begin
                        state_reg <= ST_COMPACT;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_COMPACT:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= (cmd_reg.action == lobm_pkg::ACT_CANCEL) ?
                                     ST_IDLE : ST_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                ST_FINISH:
                begin
                    result_reg     <= final_result;
                    pend_valid_reg <= 1'b0;
                    if (final_outcome == lobm_pkg::OUT_RESTED)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ORDER_SLOTS))
        else $error("order count exceeds the number of cells");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.is_trade |-> result.last)
        else $error("status-only result not marked last");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer accepted without going busy");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("trade left undelivered at end of item");

endmodule
